/* rtl/core/pn3d_pkg.sv */
// Package with the permutation table, widths and arithmetic helpers of the 3D noise core.
package pn3d_pkg;

	localparam int NQ = 16;
	localparam int VAL_W = 21;

	typedef logic signed [17:0] coord_q_t;
	typedef logic signed [17:0] fade_t;
	typedef logic signed [18:0] dot_t;
	typedef logic signed [VAL_W-1:0] val_t;

	localparam logic [7:0] PERM [256] = '{
		8'd151, 8'd160, 8'd137, 8'd91, 8'd90, 8'd15, 8'd131, 8'd13, 8'd201, 8'd95,
		8'd96, 8'd53, 8'd194, 8'd233, 8'd7, 8'd225, 8'd140, 8'd36, 8'd103, 8'd30,
		8'd69, 8'd142, 8'd8, 8'd99, 8'd37, 8'd240, 8'd21, 8'd10, 8'd23, 8'd190,
		8'd6, 8'd148, 8'd247, 8'd120, 8'd234, 8'd75, 8'd0, 8'd26, 8'd197, 8'd62,
		8'd94, 8'd252, 8'd219, 8'd203, 8'd117, 8'd35, 8'd11, 8'd32, 8'd57, 8'd177,
		8'd33, 8'd88, 8'd237, 8'd149, 8'd56, 8'd87, 8'd174, 8'd20, 8'd125, 8'd136,
		8'd171, 8'd168, 8'd68, 8'd175, 8'd74, 8'd165, 8'd71, 8'd134, 8'd139, 8'd48,
		8'd27, 8'd166, 8'd77, 8'd146, 8'd158, 8'd231, 8'd83, 8'd111, 8'd229, 8'd122,
		8'd60, 8'd211, 8'd133, 8'd230, 8'd220, 8'd105, 8'd92, 8'd41, 8'd55, 8'd46,
		8'd245, 8'd40, 8'd244, 8'd102, 8'd143, 8'd54, 8'd65, 8'd25, 8'd63, 8'd161,
		8'd1, 8'd216, 8'd80, 8'd73, 8'd209, 8'd76, 8'd132, 8'd187, 8'd208, 8'd89,
		8'd18, 8'd169, 8'd200, 8'd196, 8'd135, 8'd130, 8'd116, 8'd188, 8'd159, 8'd86,
		8'd164, 8'd100, 8'd109, 8'd198, 8'd173, 8'd186, 8'd3, 8'd64, 8'd52, 8'd217,
		8'd226, 8'd250, 8'd124, 8'd123, 8'd5, 8'd202, 8'd38, 8'd147, 8'd118, 8'd126,
		8'd255, 8'd82, 8'd85, 8'd212, 8'd207, 8'd206, 8'd59, 8'd227, 8'd47, 8'd16,
		8'd58, 8'd17, 8'd182, 8'd189, 8'd28, 8'd42, 8'd223, 8'd183, 8'd170, 8'd213,
		8'd119, 8'd248, 8'd152, 8'd2, 8'd44, 8'd154, 8'd163, 8'd70, 8'd221, 8'd153,
		8'd101, 8'd155, 8'd167, 8'd43, 8'd172, 8'd9, 8'd129, 8'd22, 8'd39, 8'd253,
		8'd19, 8'd98, 8'd108, 8'd110, 8'd79, 8'd113, 8'd224, 8'd232, 8'd178, 8'd185,
		8'd112, 8'd104, 8'd218, 8'd246, 8'd97, 8'd228, 8'd251, 8'd34, 8'd242, 8'd193,
		8'd238, 8'd210, 8'd144, 8'd12, 8'd191, 8'd179, 8'd162, 8'd241, 8'd81, 8'd51,
		8'd145, 8'd235, 8'd249, 8'd14, 8'd239, 8'd107, 8'd49, 8'd192, 8'd214, 8'd31,
		8'd181, 8'd199, 8'd106, 8'd157, 8'd184, 8'd84, 8'd204, 8'd176, 8'd115, 8'd121,
		8'd50, 8'd45, 8'd127, 8'd4, 8'd150, 8'd254, 8'd138, 8'd236, 8'd205, 8'd93,
		8'd222, 8'd114, 8'd67, 8'd29, 8'd24, 8'd72, 8'd243, 8'd141, 8'd128, 8'd195,
		8'd78, 8'd66, 8'd215, 8'd61, 8'd156, 8'd180
	};

	function automatic dot_t grad_dot(input logic [3:0] h, input coord_q_t x,
			input coord_q_t y, input coord_q_t z);
		coord_q_t u;
		coord_q_t v;
		dot_t su;
		dot_t sv;
		u = (h < 4'd8) ? x : y;
		if (h < 4'd4) begin
			v = y;
		end else if (h == 4'd12 || h == 4'd14) begin
			v = x;
		end else begin
			v = z;
		end
		su = h[0] ? -19'(u) : 19'(u);
		sv = h[1] ? -19'(v) : 19'(v);
		return su + sv;
	endfunction

	function automatic val_t blend(input fade_t t, input val_t a, input val_t b);
		logic signed [VAL_W:0] d;
		logic signed [39:0] p;
		logic signed [39:0] q;
		d = (VAL_W+1)'(b) - (VAL_W+1)'(a);
		p = 40'(t) * 40'(d);
		q = (p + 40'sd32768) >>> NQ;
		return VAL_W'(q + 40'(a));
	endfunction

endpackage

/* rtl/core/perlin_noise_3d_core.sv */
// Pipelined improved 3D gradient noise core, one point per word.
// A new point is accepted in every cycle while the output word is not stalled; the whole
// pipeline holds while the output word is stalled, so in_stall follows out_stall
// whenever the output register is full.
module perlin_noise_3d_core #(
	parameter int COORD_FRAC_BITS = 16,
	parameter int OUT_FRAC_BITS = 14
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic signed [23:0]  coord_x,
	input  logic signed [23:0]  coord_y,
	input  logic signed [23:0]  coord_z,
	output logic                out_valid,
	input  logic                out_stall,
	output logic signed [15:0]  noise_value
);

	localparam logic [31:0] FRAC_MASK = (32'd1 << COORD_FRAC_BITS) - 32'd1;
	localparam int SH = pn3d_pkg::NQ - OUT_FRAC_BITS;

	logic adv;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;

	logic [7:0] cell_c [3];
	logic [15:0] frac_c [3];
	logic signed [16:0] t_c [3];
	logic signed [16:0] t2_c [3];
	logic signed [20:0] h_c [3];

	logic [7:0] cy_s1, cz_s1, pa_s1, pb_s1;
	logic signed [16:0] t_s1 [3];
	logic signed [16:0] t2_s1 [3];
	logic signed [20:0] h_s1 [3];

	logic [7:0] aa_s2, ab_s2, ba_s2, bb_s2;
	logic signed [16:0] t_s2 [3];
	logic signed [16:0] t3_s2 [3];
	logic signed [20:0] h_s2 [3];

	pn3d_pkg::fade_t fade_s3 [3];
	pn3d_pkg::dot_t dot_s3 [8];

	pn3d_pkg::fade_t fv_s4, fw_s4;
	pn3d_pkg::val_t l_s4 [4];
	pn3d_pkg::fade_t fw_s5;
	pn3d_pkg::val_t m_s5 [2];
	pn3d_pkg::val_t n_s6;
	logic signed [15:0] noise_s7;

	logic signed [23:0] r_c;

	assign adv = !(v_s7 && out_stall);
	assign in_stall = !adv;
	assign out_valid = v_s7;
	assign noise_value = noise_s7;

	always_comb begin
		logic [31:0] ext;
		logic [35:0] fw;
		logic signed [37:0] ph;
		logic signed [33:0] p2;
		logic signed [20:0] d6;
		for (int i = 0; i < 3; i++) begin
			ext = (i == 0) ? 32'(coord_x) : ((i == 1) ? 32'(coord_y) : 32'(coord_z));
			fw = 36'(ext & FRAC_MASK) << 16;
			cell_c[i] = ext[COORD_FRAC_BITS +: 8];
			frac_c[i] = fw[COORD_FRAC_BITS +: 16];
			t_c[i] = signed'({1'b0, frac_c[i]});
			p2 = 34'(t_c[i]) * 34'(t_c[i]);
			t2_c[i] = 17'((p2 + 34'sd32768) >>> 16);
			d6 = (21'(t_c[i]) <<< 1) + (21'(t_c[i]) <<< 2) - 21'sd983040;
			ph = 38'(t_c[i]) * 38'(d6);
			h_c[i] = 21'((ph + 38'sd32768) >>> 16) + 21'sd655360;
		end
	end

	always_comb begin
		logic signed [23:0] half;
		half = 24'sd1 <<< (SH - 1);
		r_c = (24'(n_s6) + half) >>> SH;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		logic [7:0] a, b;
		logic signed [33:0] p3;
		logic signed [39:0] pf;
		pn3d_pkg::coord_q_t x0, y0, z0, x1, y1, z1;
		if (adv) begin
			// Stage 1: cell split, fade partial products, first hash level.
			cy_s1 <= cell_c[1];
			cz_s1 <= cell_c[2];
			pa_s1 <= pn3d_pkg::PERM[cell_c[0]];
			pb_s1 <= pn3d_pkg::PERM[cell_c[0] + 8'd1];
			for (int i = 0; i < 3; i++) begin
				t_s1[i] <= t_c[i];
				t2_s1[i] <= t2_c[i];
				h_s1[i] <= h_c[i];
			end

			// Stage 2: t cubed and the second hash level.
			a = pa_s1 + cy_s1;
			b = pb_s1 + cy_s1;
			aa_s2 <= pn3d_pkg::PERM[a] + cz_s1;
			ab_s2 <= pn3d_pkg::PERM[a + 8'd1] + cz_s1;
			ba_s2 <= pn3d_pkg::PERM[b] + cz_s1;
			bb_s2 <= pn3d_pkg::PERM[b + 8'd1] + cz_s1;
			for (int i = 0; i < 3; i++) begin
				p3 = 34'(t2_s1[i]) * 34'(t_s1[i]);
				t_s2[i] <= t_s1[i];
				t3_s2[i] <= 17'((p3 + 34'sd32768) >>> 16);
				h_s2[i] <= h_s1[i];
			end

			// Stage 3: fade values and the eight corner gradient dots.
			for (int i = 0; i < 3; i++) begin
				pf = 40'(t3_s2[i]) * 40'(h_s2[i]);
				fade_s3[i] <= 18'((pf + 40'sd32768) >>> 16);
			end
			x0 = 18'(t_s2[0]);
			y0 = 18'(t_s2[1]);
			z0 = 18'(t_s2[2]);
			x1 = x0 - 18'sd65536;
			y1 = y0 - 18'sd65536;
			z1 = z0 - 18'sd65536;
			dot_s3[0] <= pn3d_pkg::grad_dot(pn3d_pkg::PERM[aa_s2][3:0], x0, y0, z0);
			dot_s3[1] <= pn3d_pkg::grad_dot(pn3d_pkg::PERM[ba_s2][3:0], x1, y0, z0);
			dot_s3[2] <= pn3d_pkg::grad_dot(pn3d_pkg::PERM[ab_s2][3:0], x0, y1, z0);
			dot_s3[3] <= pn3d_pkg::grad_dot(pn3d_pkg::PERM[bb_s2][3:0], x1, y1, z0);
			dot_s3[4] <= pn3d_pkg::grad_dot(pn3d_pkg::PERM[aa_s2 + 8'd1][3:0], x0, y0, z1);
			dot_s3[5] <= pn3d_pkg::grad_dot(pn3d_pkg::PERM[ba_s2 + 8'd1][3:0], x1, y0, z1);
			dot_s3[6] <= pn3d_pkg::grad_dot(pn3d_pkg::PERM[ab_s2 + 8'd1][3:0], x0, y1, z1);
			dot_s3[7] <= pn3d_pkg::grad_dot(pn3d_pkg::PERM[bb_s2 + 8'd1][3:0], x1, y1, z1);

			// Stage 4 to 6: trilinear blend along x, y and z.
			fv_s4 <= fade_s3[1];
			fw_s4 <= fade_s3[2];
			for (int k = 0; k < 4; k++) begin
				l_s4[k] <= pn3d_pkg::blend(fade_s3[0], 21'(dot_s3[2*k]), 21'(dot_s3[2*k+1]));
			end
			fw_s5 <= fw_s4;
			m_s5[0] <= pn3d_pkg::blend(fv_s4, l_s4[0], l_s4[1]);
			m_s5[1] <= pn3d_pkg::blend(fv_s4, l_s4[2], l_s4[3]);
			n_s6 <= pn3d_pkg::blend(fw_s5, m_s5[0], m_s5[1]);

			// Stage 7: output rounding and saturation.
			if (r_c > 24'sd32767) begin
				noise_s7 <= 16'sh7fff;
			end else if (r_c < -24'sd32768) begin
				noise_s7 <= -16'sh8000;
			end else begin
				noise_s7 <= 16'(r_c);
			end
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> ($stable({v_s1, v_s2, v_s3, v_s4, v_s5, v_s6})
			&& $stable(noise_value) && out_valid))
		else $error("pipeline moved while the output word was stalled");

	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> v_s1)
		else $error("accepted input word did not enter the pipeline");

	a_bubble: assert property (@(posedge clk) disable iff (!arst_n)
		(!in_valid && !in_stall) |=> !v_s1)
		else $error("pipeline invented a word");

endmodule
